// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue: sizes, codes and the entry type.
// Used by spq_cell and sorted_priority_queue_unit; depends on nothing.
package spq_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] id;
    logic [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts it with its neighbors.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  logic       left_gt,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       gt
);

  entry_t entry_r;
  entry_t entry_nxt;

  // An empty slot or a strictly larger priority lets the new entry pass ahead.
  assign gt = !occupied || (entry_r.prio > new_entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert && gt) begin
      entry_nxt = left_gt ? left_entry : new_entry;
    end else if (ctrl.remove) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
// Top level of the sorted priority queue: a row of spq_cell slots and the count.
// Depends on spq_pkg and spq_cell.
//
// Input channel in_*: one item per operation. in_tuser carries the kind (insert
// or remove the head), in_tdata the entry to insert; the entry is ignored on a
// remove. Result channel out_*: exactly one item per operation, carrying the
// status in out_tuser and the removed entry, the new head and the occupancy in
// out_tdata. The slots sit in a chain sorted by priority, slot 0 at the head;
// every slot compares its priority with the new one in parallel and shifts
// by one place in the same cycle. The result of an accepted operation is
// registered in the output register, and one item is accepted per cycle
// while the receiver takes results. When the receiver stalls, the result
// waits in the output register and in_tready stays low until it is taken.
// Reset empties the queue and the output register; slot contents are not
// cleared, as the count marks which slots are in use.
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // entry_priority, entry_id, entry_arrival
  input  logic [0:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // removed_id, removed_arrival, head_valid,
                                  // head_arrival, occupancy, zero pad
  output logic [1:0]  out_tuser   // status
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [55:0]      out_data_r;
  logic [55:0]      out_data_nxt;
  status_t          out_status_r;
  status_t          out_status_nxt;

  entry_t     new_entry;
  kind_t      kind;
  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;
  entry_t     cell_entry [DEPTH];
  logic       cell_gt    [DEPTH];

  status_t     status;
  logic [15:0] removed_id;
  logic [15:0] removed_arrival;
  logic        head_valid;
  logic [15:0] head_arrival;

  assign new_entry.prio     = in_tdata[15:0];
  assign new_entry.id       = in_tdata[31:16];
  assign new_entry.arrival  = in_tdata[47:32];
  assign kind               = kind_t'(in_tuser[0]);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctrl.insert = accept && (kind == KIND_INSERT) && !full;
  assign ctrl.remove = accept && (kind == KIND_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    entry_t left_entry;
    logic   left_gt;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_gt    = 1'b0;
    end else begin : g_rest
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (IDX < count_r),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt       = count_r;
    status          = ST_DONE;
    removed_id      = '0;
    removed_arrival = '0;
    head_arrival    = cell_entry[0].arrival;
    if (kind == KIND_INSERT) begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        count_nxt = count_r + 1'b1;
        if (cell_gt[0]) begin
          head_arrival = new_entry.arrival;
        end
      end
    end else begin
      if (empty) begin
        status = ST_UNDERFLOW;
      end else begin
        count_nxt       = count_r - 1'b1;
        removed_id      = cell_entry[0].id;
        removed_arrival = cell_entry[0].arrival;
        head_arrival    = cell_entry[1].arrival;
      end
    end
    head_valid = (count_nxt != '0);
    if (!head_valid) begin
      head_arrival = '0;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status;
      out_data_nxt   = {1'b0, 6'(count_nxt), head_arrival, head_valid,
                        removed_arrival, removed_id};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
